// ----- src/vrt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the rectangle transfer engine.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int unsigned StoreWidthDef  = 1024;
  localparam int unsigned StoreHeightDef = 512;
  localparam int unsigned CoordW         = 17;

  typedef enum logic [2:0] {
    OP_OPEN_WR = 3'd0,
    OP_OPEN_RD = 3'd1,
    OP_COPY    = 3'd2,
    OP_DATA    = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WR0,
    ST_WR1,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CP_RD,
    ST_CP_WR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic open_rect;
    logic cp_setup;
    logic wr_lo;
    logic wr_hi;
    logic rd_lo;
    logic rd_hi;
    logic rd_cap_lo;
    logic rd_cap_hi;
    logic cp_rd;
    logic cp_wr;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  rect_empty;
    logic  adv_done;
    logic  cp_empty;
    logic  cp_last;
    mode_e mode;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/vrt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_ctrl
// Command sequencer: clearing pass, op decode, memory access steps, result.
// ----------------------------------------------------------------------------
module vrt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [2:0]     op_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_ready_i,
  input  wire vrt_pkg::stat_t stat_i,
  output vrt_pkg::cmd_t       cmd_o
);
  import vrt_pkg::*;

  state_e state_q, state_d;
  logic [2:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_ready_o && in_valid_i) op_q <= op_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        unique case (op_q)
          OP_OPEN_WR, OP_OPEN_RD: state_d = ST_OUT;
          OP_COPY: state_d = ST_CP_RD;
          OP_DATA: state_d = (stat_i.mode == MODE_WRITE) ? ST_WR0 : ST_OUT;
          OP_READ: state_d = (stat_i.mode == MODE_READ) ? ST_RD0 : ST_OUT;
          default: state_d = ST_OUT;
        endcase
      end
      ST_WR0:   state_d = stat_i.adv_done ? ST_OUT : ST_WR1;
      ST_WR1:   state_d = ST_OUT;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_OUT;
      ST_CP_RD: state_d = stat_i.cp_empty ? ST_OUT : ST_CP_WR;
      ST_CP_WR: state_d = stat_i.cp_last ? ST_OUT : ST_CP_RD;
      ST_OUT:   if (!out_valid_i || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE:  in_ready_o = 1'b1;
      ST_DECODE: begin
        cmd_o.open_rect = (op_q == OP_OPEN_WR) || (op_q == OP_OPEN_RD);
        cmd_o.cp_setup  = (op_q == OP_COPY);
      end
      ST_WR0:   cmd_o.wr_lo = 1'b1;
      ST_WR1:   cmd_o.wr_hi = 1'b1;
      ST_RD0:   cmd_o.rd_lo = 1'b1;
      ST_RD1: begin
        cmd_o.rd_hi     = 1'b1;
        cmd_o.rd_cap_lo = 1'b1;
      end
      ST_RD2:   cmd_o.rd_cap_hi = 1'b1;
      ST_CP_RD: cmd_o.cp_rd = 1'b1;
      ST_CP_WR: cmd_o.cp_wr = 1'b1;
      ST_OUT: cmd_o.res_load = !out_valid_i || out_ready_i;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && in_valid_i |=> state_q == ST_DECODE) else $error("no decode");
  a_one_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wr_lo, cmd_o.wr_hi, cmd_o.cp_wr})) else $error("two writes");
`endif

endmodule
`default_nettype wire

// ----- src/vrt_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_datapath
// Pixel memory, cursor and rectangle registers, copy counters, result reg.
// ----------------------------------------------------------------------------
module vrt_datapath #(
  parameter int unsigned StoreWidth  = vrt_pkg::StoreWidthDef,
  parameter int unsigned StoreHeight = vrt_pkg::StoreHeightDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_accept_i,
  input  wire logic [2:0]     op_i,
  input  wire logic [9:0]     src_x_i,
  input  wire logic [8:0]     src_y_i,
  input  wire logic [9:0]     dst_x_i,
  input  wire logic [8:0]     dst_y_i,
  input  wire logic [15:0]    rect_width_i,
  input  wire logic [15:0]    rect_height_i,
  input  wire logic [31:0]    data_word_i,
  input  wire vrt_pkg::cmd_t  cmd_i,
  output vrt_pkg::stat_t      stat_o,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output logic [31:0]         read_data_o,
  output logic [1:0]          transfer_mode_o,
  output logic                finished_o
);
  import vrt_pkg::*;

  localparam int unsigned XW = $clog2(StoreWidth);
  localparam int unsigned YW = $clog2(StoreHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned Depth = StoreWidth * StoreHeight;
  localparam logic [CoordW-1:0] SwC = CoordW'(StoreWidth);
  localparam logic [CoordW-1:0] ShC = CoordW'(StoreHeight);

  // input item registers
  logic [2:0]  op_q;
  logic [9:0]  sx_q, dx_q;
  logic [8:0]  sy_q, dy_q;
  logic [15:0] w_q, h_q;
  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      op_q <= op_i; sx_q <= src_x_i; sy_q <= src_y_i; dx_q <= dst_x_i;
      dy_q <= dst_y_i; w_q <= rect_width_i; h_q <= rect_height_i;
      word_q <= data_word_i;
    end
  end

  // transfer state
  logic [CoordW-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic [9:0]        start_x_q;
  mode_e             mode_q;
  logic              done_q;

  // modulo reduction of a coordinate (power-of-two store size)
  function automatic logic [XW-1:0] mod_x(input logic [CoordW-1:0] v);
    return v[XW-1:0];
  endfunction
  function automatic logic [YW-1:0] mod_y(input logic [CoordW-1:0] v);
    return v[YW-1:0];
  endfunction

  // cursor advance
  logic [1:0]        adv_n;
  logic [CoordW-1:0] adv_x, nx_x, nx_y;
  logic              adv_row, adv_fin;
  assign adv_n   = (cmd_i.rd_hi) ? 2'd2 : 2'd1;
  assign adv_x   = cur_x_q + CoordW'(adv_n);
  assign adv_row = adv_x >= end_x_q;
  assign nx_x    = adv_row ? CoordW'(start_x_q) : adv_x;
  assign nx_y    = adv_row ? cur_y_q + 1'b1 : cur_y_q;
  assign adv_fin = adv_row && (nx_y >= end_y_q);
  assign stat_o.adv_done = adv_fin;
  assign stat_o.mode = mode_q;
  assign stat_o.rect_empty = (w_q == '0) || (h_q == '0);

  // copy setup and counters
  logic [XW-1:0] csx_q, cdx_q;
  logic [YW-1:0] csy_q, cdy_q;
  logic [CoordW-1:0] cw_q, ch_q, cc_q, cr_q;
  logic [XW-1:0] msx, mdx;
  logic [YW-1:0] msy, mdy;
  logic [CoordW-1:0] cw1, cw2, ch1, ch2;
  always_comb begin
    msx = mod_x(CoordW'(sx_q));
    mdx = mod_x(CoordW'(dx_q));
    msy = mod_y(CoordW'(sy_q));
    mdy = mod_y(CoordW'(dy_q));
    cw1 = (CoordW'(msx) + CoordW'(w_q) > SwC) ? SwC - CoordW'(msx) : CoordW'(w_q);
    cw2 = (CoordW'(mdx) + cw1 > SwC) ? SwC - CoordW'(mdx) : cw1;
    ch1 = (CoordW'(msy) + CoordW'(h_q) > ShC) ? ShC - CoordW'(msy) : CoordW'(h_q);
    ch2 = (CoordW'(mdy) + ch1 > ShC) ? ShC - CoordW'(mdy) : ch1;
  end
  assign stat_o.cp_empty = (cw_q == '0) || (ch_q == '0);
  assign stat_o.cp_last  = (cc_q + 1'b1 == cw_q) && (cr_q + 1'b1 == ch_q);

  // memory port
  logic [15:0] mem [Depth];
  logic [AW-1:0] clr_q;
  logic          we;
  logic [AW-1:0] addr;
  logic [15:0]   wdata, rdata_q;
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  assign stat_o.clr_last = (clr_q == AW'(Depth - 1));

  always_comb begin
    ax = mod_x(CoordW'(cur_x_q[XW-1:0]));
    ay = cur_y_q[YW-1:0];
    we = 1'b0;
    wdata = word_q[15:0];
    priority if (cmd_i.clr_step) begin
      we = 1'b1; wdata = '0;
      ax = clr_q[XW-1:0]; ay = clr_q[AW-1:XW];
    end else if (cmd_i.wr_lo) begin
      we = 1'b1;
    end else if (cmd_i.wr_hi) begin
      we = 1'b1; wdata = word_q[31:16];
    end else if (cmd_i.rd_hi) begin
      ax = cur_x_q[XW-1:0] + 1'b1;
      ay = cur_y_q[YW-1:0];
    end else if (cmd_i.cp_rd) begin
      ax = csx_q + cc_q[XW-1:0]; ay = csy_q + cr_q[YW-1:0];
    end else if (cmd_i.cp_wr) begin
      we = 1'b1; wdata = rdata_q;
      ax = cdx_q + cc_q[XW-1:0]; ay = cdy_q + cr_q[YW-1:0];
    end else begin
      ax = cur_x_q[XW-1:0];
    end
    addr = {ay, ax};
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rdata_q <= mem[addr];
  end

  // sequential state
  logic [15:0] lo_q;
  logic [31:0] rd_word_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; cur_x_q <= '0; cur_y_q <= '0; end_x_q <= '0; end_y_q <= '0;
      start_x_q <= '0; mode_q <= MODE_NONE; done_q <= 1'b0;
      cw_q <= '0; ch_q <= '0; cc_q <= '0; cr_q <= '0;
      csx_q <= '0; cdx_q <= '0; csy_q <= '0; cdy_q <= '0; lo_q <= '0; rd_word_q <= '0;
      out_valid_o <= 1'b0; read_data_o <= '0; transfer_mode_o <= '0; finished_o <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (in_accept_i) begin
        done_q <= 1'b0;
        rd_word_q <= '0;
      end
      if (cmd_i.open_rect) begin
        start_x_q <= sx_q;
        cur_x_q <= CoordW'(sx_q);
        cur_y_q <= CoordW'(sy_q);
        end_x_q <= CoordW'(sx_q) + CoordW'(w_q);
        end_y_q <= CoordW'(sy_q) + CoordW'(h_q);
        if (stat_o.rect_empty) begin
          mode_q <= MODE_NONE; done_q <= 1'b1;
        end else begin
          mode_q <= (op_q == OP_OPEN_WR) ? MODE_WRITE : MODE_READ;
        end
      end
      if (cmd_i.cp_setup) begin
        csx_q <= msx; cdx_q <= mdx; csy_q <= msy; cdy_q <= mdy;
        cw_q <= cw2; ch_q <= ch2; cc_q <= '0; cr_q <= '0; done_q <= 1'b1;
      end
      if (cmd_i.cp_wr) begin
        if (cc_q + 1'b1 == cw_q) begin
          cc_q <= '0; cr_q <= cr_q + 1'b1;
        end else begin
          cc_q <= cc_q + 1'b1;
        end
      end
      if (cmd_i.wr_lo || cmd_i.wr_hi || cmd_i.rd_hi) begin
        cur_x_q <= nx_x; cur_y_q <= nx_y;
        if (adv_fin) begin
          mode_q <= MODE_NONE; done_q <= 1'b1;
        end
      end
      if (cmd_i.rd_cap_lo) lo_q <= rdata_q;
      if (cmd_i.rd_cap_hi) rd_word_q <= {rdata_q, lo_q};
      if (cmd_i.res_load) begin
        out_valid_o <= 1'b1;
        read_data_o <= rd_word_q;
        transfer_mode_o <= mode_q;
        finished_o <= done_q;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/vram_rectangle_transfer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vram_rectangle_transfer
// Rectangle write, read and copy engine over a 16-bit pixel memory.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tdata: op, src_x, src_y, dst_x, dst_y, rect_width, rect_height, data_word
// m_axis  | out | tdata: read_data, transfer_mode, finished
//
// After reset a clearing pass zeroes the memory, one pixel per cycle,
// before the first request is taken. A data word writes two pixels, one
// when the first pixel ends the rectangle; a read word reads two pixels;
// an ignored request only returns a result. Copy: one single-port memory
// access per cycle, reading and writing in turn.
// A stalled result holds the engine in its result state.
// ----------------------------------------------------------------------------
module vram_rectangle_transfer #(
  parameter int unsigned STORE_WIDTH  = vrt_pkg::StoreWidthDef,
  parameter int unsigned STORE_HEIGHT = vrt_pkg::StoreHeightDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op[2:0] src_x[12:3] src_y[21:13] dst_x[31:22] dst_y[40:32]
  // rect_width[56:41] rect_height[72:57] data_word[104:73]
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // read_data[31:0] transfer_mode[33:32] finished[34]
  output logic [39:0]       m_axis_tdata
);
  import vrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  acc;
  logic [31:0] rd;
  logic [1:0]  tm;
  logic        fin;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {5'd0, fin, tm, rd};

  vrt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[2:0]),
    .out_valid_i(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vrt_datapath #(.StoreWidth(STORE_WIDTH), .StoreHeight(STORE_HEIGHT)) u_dp (
    .clk_i, .rst_ni,
    .in_accept_i    (acc),
    .op_i           (s_axis_tdata[2:0]),
    .src_x_i        (s_axis_tdata[12:3]),
    .src_y_i        (s_axis_tdata[21:13]),
    .dst_x_i        (s_axis_tdata[31:22]),
    .dst_y_i        (s_axis_tdata[40:32]),
    .rect_width_i   (s_axis_tdata[56:41]),
    .rect_height_i  (s_axis_tdata[72:57]),
    .data_word_i    (s_axis_tdata[104:73]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .read_data_o    (rd),
    .transfer_mode_o(tm),
    .finished_o     (fin)
  );

endmodule
`default_nettype wire

// ----- dv/vram_rectangle_transfer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vram_rectangle_transfer_checker
// Watches both stream channels of the rectangle transfer engine. Predicts
// each result from a private copy of the pixel memory and the open
// rectangle, then compares the results field by field in order.
// ----------------------------------------------------------------------------
module vram_rectangle_transfer_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  // op src_x src_y dst_x dst_y rect_width rect_height data_word
  input  wire logic [111:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // read_data transfer_mode finished
  input  wire logic [39:0]  m_axis_tdata,
  output int                err_count_o,
  output int                pending_o
);
  import vrt_pkg::*;

  localparam int unsigned SW = StoreWidthDef;
  localparam int unsigned SH = StoreHeightDef;

  typedef struct {
    logic [31:0] read_data;
    mode_e       mode;
    logic        finished;
  } xfer_res_t;

  logic [15:0]    pix_mem [SW*SH];
  logic [16:0]    cur_x, cur_y, end_x, end_y;
  logic [9:0]     start_x;
  mode_e          cur_mode;
  xfer_res_t      res_q[$];

  function automatic int unsigned pix_addr(int unsigned x, int unsigned y);
    return (y % SH) * SW + (x % SW);
  endfunction

  function automatic bit step_cursor(int unsigned n);
    cur_x = cur_x + 17'(n);
    if (cur_x >= end_x) begin
      cur_x = 17'(start_x);
      cur_y = cur_y + 17'd1;
      if (cur_y >= end_y) begin
        cur_mode = MODE_NONE;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit open_rect(mode_e m, logic [9:0] x, logic [8:0] y,
                                   logic [15:0] w, logic [15:0] h);
    start_x = x;
    cur_x   = 17'(x);
    cur_y   = 17'(y);
    end_x   = 17'(x) + 17'(w);
    end_y   = 17'(y) + 17'(h);
    if (w == 0 || h == 0) begin
      cur_mode = MODE_NONE;
      return 1'b1;
    end
    cur_mode = m;
    return 1'b0;
  endfunction

  function automatic void copy_rect(int unsigned sx, int unsigned sy, int unsigned dx,
                                    int unsigned dy, int unsigned w, int unsigned h);
    if (sx + w > SW) w = SW - sx;
    if (dx + w > SW) w = SW - dx;
    if (sy + h > SH) h = SH - sy;
    if (dy + h > SH) h = SH - dy;
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        pix_mem[pix_addr(dx + c, dy + r)] = pix_mem[pix_addr(sx + c, sy + r)];
      end
    end
  endfunction

  function automatic xfer_res_t predict_xfer(logic [111:0] d);
    xfer_res_t   res;
    logic [2:0]  op;
    logic [9:0]  sx, dx;
    logic [8:0]  sy, dy;
    logic [15:0] w, h;
    logic [31:0] word;
    op   = d[2:0];
    sx   = d[12:3];
    sy   = d[21:13];
    dx   = d[31:22];
    dy   = d[40:32];
    w    = d[56:41];
    h    = d[72:57];
    word = d[104:73];
    res.read_data = '0;
    res.finished  = 1'b0;
    case (op)
      OP_OPEN_WR: res.finished = open_rect(MODE_WRITE, sx, sy, w, h);
      OP_OPEN_RD: res.finished = open_rect(MODE_READ, sx, sy, w, h);
      OP_COPY: begin
        copy_rect(sx, sy, dx, dy, w, h);
        res.finished = 1'b1;
      end
      OP_DATA: begin
        if (cur_mode == MODE_WRITE) begin
          pix_mem[pix_addr(cur_x, cur_y)] = word[15:0];
          res.finished = step_cursor(1);
          if (!res.finished) begin
            pix_mem[pix_addr(cur_x, cur_y)] = word[31:16];
            res.finished = step_cursor(1);
          end
        end
      end
      OP_READ: begin
        if (cur_mode == MODE_READ) begin
          res.read_data = {pix_mem[pix_addr(int'(cur_x) + 1, cur_y)],
                           pix_mem[pix_addr(cur_x, cur_y)]};
          res.finished  = step_cursor(2);
        end
      end
      default: ;
    endcase
    res.mode = cur_mode;
    return res;
  endfunction

  initial begin
    foreach (pix_mem[i]) pix_mem[i] = '0;
    cur_x = '0; cur_y = '0; end_x = '0; end_y = '0; start_x = '0;
    cur_mode = MODE_NONE;
    err_count_o = 0;
  end

  assign pending_o = res_q.size();

  always @(posedge clk_i) begin
    xfer_res_t want;
    int        errs;
    errs = 0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (res_q.size() == 0) begin
          $error("result with no request pending: %h", m_axis_tdata);
          errs++;
        end else begin
          want = res_q.pop_front();
          if (m_axis_tdata[31:0] !== want.read_data) begin
            $error("read_data expected %h actual %h", want.read_data, m_axis_tdata[31:0]);
            errs++;
          end
          if (m_axis_tdata[33:32] !== want.mode) begin
            $error("transfer_mode expected %0d actual %0d", want.mode,
                   m_axis_tdata[33:32]);
            errs++;
          end
          if (m_axis_tdata[34] !== want.finished) begin
            $error("finished expected %0d actual %0d", want.finished, m_axis_tdata[34]);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) res_q.push_back(predict_xfer(s_axis_tdata));
      if (errs != 0) err_count_o <= err_count_o + errs;
    end
  end

endmodule

// ----- dv/vram_rectangle_transfer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vram_rectangle_transfer_tb
// Drives write, read and copy requests into the rectangle transfer engine:
// a directed set of edge cases, then random rectangle sequences and noise
// under several idling phases. The checker next to the engine scores them.
// ----------------------------------------------------------------------------
module vram_rectangle_transfer_tb;
  import vrt_pkg::*;

  localparam int WatchdogLimit = 3000000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;
  int           err_count;
  int           pending;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           sent;
  int           quiet_cycles;
  bit           hold_req;
  bit           hold_used;
  int           hold_cnt;

  vram_rectangle_transfer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vram_rectangle_transfer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = 400;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [111:0] pack_req(logic [2:0] op, logic [9:0] sx, logic [8:0] sy,
                                            logic [9:0] dx, logic [8:0] dy, logic [15:0] w,
                                            logic [15:0] h, logic [31:0] word);
    return {7'd0, word, h, w, dy, dx, sy, sx, op};
  endfunction

  task automatic send_req(logic [111:0] d);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic set_phase(int p);
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [9:0]  x, dx;
    logic [8:0]  y, dy;
    logic [15:0] w, h;
    int          n, kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet_cycles  = 0;
    hold_req      = 1'b0;
    hold_used     = 1'b0;
    sent          = 0;
    set_phase(0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: wrap at the corner, discard inside a word, odd read width
    send_req(pack_req(OP_DATA, 0, 0, 0, 0, 4, 4, 32'hffff_ffff));
    send_req(pack_req(OP_READ, 0, 0, 0, 0, 4, 4, 0));
    send_req(pack_req(OP_OPEN_WR, 10'h3ff, 9'h1ff, 0, 0, 3, 2, 0));
    send_req(pack_req(OP_DATA, 0, 0, 0, 0, 0, 0, 32'hffff_ffff));
    send_req(pack_req(OP_DATA, 0, 0, 0, 0, 0, 0, 32'h1234_abcd));
    send_req(pack_req(OP_DATA, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
    send_req(pack_req(OP_OPEN_WR, 10'h3fe, 9'h1ff, 0, 0, 3, 1, 0));
    send_req(pack_req(OP_DATA, 0, 0, 0, 0, 0, 0, 32'h5555_aaaa));
    send_req(pack_req(OP_DATA, 0, 0, 0, 0, 0, 0, 32'hdead_beef));
    send_req(pack_req(OP_OPEN_RD, 10'h3ff, 9'h1ff, 0, 0, 3, 2, 0));
    send_req(pack_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_req(pack_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_req(pack_req(OP_COPY, 10'h3fc, 9'h1fc, 0, 0, 16'hffff, 16'hffff, 0));
    send_req(pack_req(OP_COPY, 0, 0, 10'h3fe, 9'h1fe, 16'hffff, 16'hffff, 0));
    send_req(pack_req(OP_COPY, 5, 5, 6, 5, 0, 3, 0));
    send_req(pack_req(OP_OPEN_RD, 0, 0, 0, 0, 8, 0, 0));
    send_req(pack_req(OP_OPEN_WR, 0, 0, 0, 0, 0, 8, 0));
    send_req(pack_req(OP_OPEN_WR, 10'h3ff, 9'h1ff, 0, 0, 16'hffff, 16'hffff, 0));
    send_req(pack_req(OP_COPY, 0, 0, 1, 0, 4, 2, 0));
    send_req(pack_req(OP_DATA, 0, 0, 0, 0, 0, 0, 32'h0bad_f00d));
    send_req(pack_req(OP_OPEN_RD, 0, 0, 0, 0, 2, 1, 0));
    send_req(pack_req(3'd5, 0, 0, 0, 0, 0, 0, 0));
    send_req(pack_req(3'd7, 10'h3ff, 9'h1ff, 10'h3ff, 9'h1ff, 16'hffff, 16'hffff, '1));
    send_req(pack_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    while (sent < 824) begin
      set_phase(sent / 100);
      if (sent > 300 && !hold_used) begin
        hold_req  = 1'b1;
        hold_used = 1'b1;
      end
      if (sent > 500 && sent < 520) wait_drained();
      x = 10'($urandom); y = 9'($urandom); dx = 10'($urandom); dy = 9'($urandom);
      w = 16'($urandom_range(1, 8)); h = 16'($urandom_range(1, 4));
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        send_req(pack_req(OP_OPEN_WR, x, y, 0, 0, w, h, 0));
        n = (w * h + 1) / 2 + $urandom_range(0, 1) - $urandom_range(0, 1);
        repeat (n) send_req(pack_req(OP_DATA, 10'($urandom), 9'($urandom), 0, 0,
                                     16'($urandom), 16'($urandom), $urandom));
      end else if (kind < 6) begin
        send_req(pack_req(OP_OPEN_RD, x, y, 0, 0, w, h, 0));
        n = ((w + 1) / 2) * h + $urandom_range(0, 1) - $urandom_range(0, 1);
        repeat (n) send_req(pack_req(OP_READ, 0, 0, 10'($urandom), 9'($urandom), 0, 0,
                                     $urandom));
      end else if (kind < 8) begin
        send_req(pack_req(OP_COPY, x, y, dx, dy, 16'($urandom_range(0, 12)),
                          16'($urandom_range(0, 12)), $urandom));
      end else begin
        send_req(pack_req(3'($urandom), x, y, dx, dy, 16'($urandom), 16'($urandom),
                          $urandom) & ~(112'h1 << 0));
        send_req(pack_req(3'($urandom_range(3, 7)), x, y, dx, dy, 16'($urandom),
                          16'($urandom), $urandom));
      end
    end
    hold_req = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/vrt_pkg.sv
src/vrt_ctrl.sv
src/vrt_datapath.sv
src/vram_rectangle_transfer.sv
dv/vram_rectangle_transfer_checker.sv
dv/vram_rectangle_transfer_tb.sv
